// ===== hdl/socc_pkg.sv =====
// shared types, widths and helpers for the segment obstacle clearance check
package socc_pkg;

   localparam int COORD_W = 32;            // coordinate field width
   localparam int DIFF_W  = COORD_W + 1;   // difference of two coordinates
   localparam int MAG_W   = COORD_W + 2;   // magnitude of any operand fed to the multiplier
   localparam int SUM_W   = 2 * MAG_W;     // unsigned sum of three squares
   localparam int ACC_W   = SUM_W + 1;     // signed accumulator
   localparam int T_BITS  = 16;            // fraction bits of the projection parameter
   localparam int ROOT_W  = MAG_W;         // square root of a SUM_W radicand
   localparam int DIST_W  = 32;            // distance output width
   localparam logic [31:0] THRESH_RESET = 32'd19661;

   typedef struct packed {
      logic start;
      logic clear;
      logic negate;
   } mac_cmd_type;

   // magnitude of a signed value one bit wider than the result
   function automatic logic [MAG_W-1:0] abs_mag(input logic [MAG_W:0] v);
      logic [MAG_W:0] n;
      n = ~v + 1'b1;
      return v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
   endfunction

endpackage

// ===== hdl/socc_serial_mac.sv =====
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
module socc_serial_mac (
   input  logic                                 clock,
   input  logic                                 reset,
   input  socc_pkg::mac_cmd_type                cmd,
   input  logic [socc_pkg::MAG_W-1:0]           mcand,
   input  logic [socc_pkg::MAG_W-1:0]           mplier,
   output logic                                 done,
   output logic signed [socc_pkg::ACC_W-1:0]    acc
);
   import socc_pkg::*;

   localparam int CNT_W = $clog2(MAG_W + 1);

   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] mcand_ff, mcand_in;
   logic [MAG_W-1:0] mplier_ff, mplier_in;
   logic neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (cmd.start) begin
         mcand_in  = ACC_W'(mcand);
         mplier_in = mplier;
         neg_in    = cmd.negate;
         cnt_in    = CNT_W'(MAG_W);
         if (cmd.clear) begin
            acc_in = '0;
         end
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = neg_ff ? acc_ff - $signed(mcand_ff) : acc_ff + $signed(mcand_ff);
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         done_in   = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      neg_ff    <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;

endmodule

// ===== hdl/socc_divider.sv =====
// restoring fraction divider, one quotient bit per cycle
module socc_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [socc_pkg::SUM_W-1:0]           numer,
   input  logic [socc_pkg::SUM_W-1:0]           denom,
   output logic                                 done,
   output logic [socc_pkg::T_BITS-1:0]          quot
);
   import socc_pkg::*;

   localparam int CNT_W = $clog2(T_BITS + 1);
   localparam int REM_W = SUM_W + 2;

   logic [REM_W-1:0] rem_ff, rem_in, rem_sh;
   logic [SUM_W-1:0] den_ff, den_in;
   logic [T_BITS-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-2:0], 1'b0};
      if (start) begin
         rem_in  = REM_W'(numer);
         den_in  = denom;
         quot_in = '0;
         cnt_in  = CNT_W'(T_BITS);
      end else if (cnt_ff != '0) begin
         if (rem_sh >= REM_W'(den_ff)) begin
            rem_in  = rem_sh - REM_W'(den_ff);
            quot_in = {quot_ff[T_BITS-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            quot_in = {quot_ff[T_BITS-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== hdl/socc_sqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
module socc_sqrt (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [socc_pkg::SUM_W-1:0]           radicand,
   output logic                                 done,
   output logic [socc_pkg::ROOT_W-1:0]          root
);
   import socc_pkg::*;

   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam int REM_W = ROOT_W + 3;

   logic [SUM_W-1:0] x_ff, x_in;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic done_ff, done_in;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[REM_W-3:0], x_ff[SUM_W-1:SUM_W-2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         x_in    = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
      end else if (cnt_ff != '0) begin
         x_in = x_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hdl/segment_obstacle_clearance_check.sv =====
// top level: point to 3d segment clearance check with sticky blocked flag
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_ready     segment start, end, obstacle, last flag
//   rsp_      out        rsp_valid / rsp_ready     distance, is_near, path_blocked, list_done
//   csr_      in         csr_write_enable          near_threshold (csr_write_data)
//
// one transaction at a time, run by the shared bit-serial multiply-accumulate unit
// (twelve products, each a start, one step per multiplier bit and done), the divider
// when t does not clamp, the square root, the output state and the idle state
// reset clears the sequencer, the sticky blocked flag and the response valid, and loads the default threshold
// a finished result waits in the output register; the next transaction is taken meanwhile
// and only its own result waits for rsp_ready
module segment_obstacle_clearance_check (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_start_x,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_start_y,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_start_z,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_end_x,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_end_y,
   input  logic signed [socc_pkg::COORD_W-1:0] req_seg_end_z,
   input  logic signed [socc_pkg::COORD_W-1:0] req_obstacle_x,
   input  logic signed [socc_pkg::COORD_W-1:0] req_obstacle_y,
   input  logic signed [socc_pkg::COORD_W-1:0] req_obstacle_z,
   input  logic                                req_last_obstacle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [socc_pkg::DIST_W-1:0]         rsp_distance,
   output logic                                rsp_is_near,
   output logic                                rsp_path_blocked,
   output logic                                rsp_list_done,
   input  logic                                csr_write_enable,
   input  logic [31:0]                         csr_write_data
);
   import socc_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_MAC, S_DIV, S_SQRT, S_OUT} state_type;
   // which product the serial unit is working on
   typedef enum logic [1:0] {P_LEN, P_DOT, P_PROJ, P_SQ} phase_type;

   localparam logic [T_BITS:0] T_ONE = {1'b1, {T_BITS{1'b0}}};

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [1:0] k_ff, k_in;
   logic issued_ff, issued_in;
   logic signed [DIFF_W-1:0] d_ff [3];
   logic signed [DIFF_W-1:0] d_in [3];
   logic signed [DIFF_W-1:0] w_ff [3];
   logic signed [DIFF_W-1:0] w_in [3];
   logic [MAG_W-1:0] emag_ff [3];
   logic [MAG_W-1:0] emag_in [3];
   logic [SUM_W-1:0] len2_ff, len2_in;
   logic [T_BITS:0] t_ff, t_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic last_ff, last_in;
   logic blocked_ff, blocked_in;
   logic [31:0] thr_ff, thr_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic rsp_is_near_ff, rsp_is_near_in;
   logic rsp_path_blocked_ff, rsp_path_blocked_in;
   logic rsp_list_done_ff, rsp_list_done_in;

   // datapath units
   mac_cmd_type mac_cmd;
   logic [MAG_W-1:0] mac_mcand, mac_mplier;
   logic mac_done;
   logic signed [ACC_W-1:0] mac_acc;
   logic div_start, div_done;
   logic [T_BITS-1:0] div_quot;
   logic sqrt_start, sqrt_done;
   logic [ROOT_W-1:0] sqrt_root;

   logic signed [DIFF_W-1:0] dk, wk;
   logic [MAG_W-1:0] dmag, wmag;
   logic [MAG_W-1:0] q_sel;
   logic [MAG_W:0] e_val;
   logic dot_le0;
   logic near, blocked, out_load;

   socc_serial_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mac_cmd),
      .mcand  (mac_mcand),
      .mplier (mac_mplier),
      .done   (mac_done),
      .acc    (mac_acc)
   );

   socc_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (mac_acc[SUM_W-1:0]),
      .denom (len2_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   socc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mac_acc[SUM_W-1:0]),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // operand selection for the current axis
   assign dk   = d_ff[k_ff];
   assign wk   = w_ff[k_ff];
   assign dmag = abs_mag({dk[DIFF_W-1], dk[DIFF_W-1], dk});
   assign wmag = abs_mag({wk[DIFF_W-1], wk[DIFF_W-1], wk});

   // projected offset: signed product shifted right, rounding toward minus infinity
   assign q_sel = mac_acc[MAG_W+T_BITS-1:T_BITS];
   assign e_val = {wk[DIFF_W-1], wk[DIFF_W-1], wk} - {q_sel[MAG_W-1], q_sel};

   // dot product not positive
   assign dot_le0 = mac_acc[ACC_W-1] || (mac_acc == '0);

   always_comb begin
      mac_cmd.start  = (state_ff == S_MAC) && !issued_ff;
      mac_cmd.clear  = (k_ff == 2'd0);
      mac_cmd.negate = 1'b0;
      mac_mcand      = dmag;
      mac_mplier     = dmag;
      case (phase_ff)
         P_LEN: begin
            mac_mcand  = dmag;
            mac_mplier = dmag;
         end
         P_DOT: begin
            mac_mcand      = wmag;
            mac_mplier     = dmag;
            mac_cmd.negate = dk[DIFF_W-1] ^ wk[DIFF_W-1];
         end
         P_PROJ: begin
            mac_mcand      = dmag;
            mac_mplier     = MAG_W'(t_ff);
            mac_cmd.negate = dk[DIFF_W-1];
            mac_cmd.clear  = 1'b1;
         end
         default: begin
            mac_mcand  = emag_ff[k_ff];
            mac_mplier = emag_ff[k_ff];
         end
      endcase
   end

   assign near     = dist_ff < thr_ff;
   assign blocked  = blocked_ff || near;
   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in            = state_ff;
      phase_in            = phase_ff;
      k_in                = k_ff;
      issued_in           = issued_ff;
      d_in                = d_ff;
      w_in                = w_ff;
      emag_in             = emag_ff;
      len2_in             = len2_ff;
      t_in                = t_ff;
      dist_in             = dist_ff;
      last_in             = last_ff;
      blocked_in          = blocked_ff;
      thr_in              = thr_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_distance_in     = rsp_distance_ff;
      rsp_is_near_in      = rsp_is_near_ff;
      rsp_path_blocked_in = rsp_path_blocked_ff;
      rsp_list_done_in    = rsp_list_done_ff;
      div_start           = 1'b0;
      sqrt_start          = 1'b0;

      if (csr_write_enable) begin
         thr_in = csr_write_data;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // direction d = end - start, offset w = obstacle - start
               d_in[0]   = DIFF_W'(req_seg_end_x) - DIFF_W'(req_seg_start_x);
               d_in[1]   = DIFF_W'(req_seg_end_y) - DIFF_W'(req_seg_start_y);
               d_in[2]   = DIFF_W'(req_seg_end_z) - DIFF_W'(req_seg_start_z);
               w_in[0]   = DIFF_W'(req_obstacle_x) - DIFF_W'(req_seg_start_x);
               w_in[1]   = DIFF_W'(req_obstacle_y) - DIFF_W'(req_seg_start_y);
               w_in[2]   = DIFF_W'(req_obstacle_z) - DIFF_W'(req_seg_start_z);
               last_in   = req_last_obstacle;
               phase_in  = P_LEN;
               k_in      = 2'd0;
               issued_in = 1'b0;
               state_in  = S_MAC;
            end
         end
         S_MAC: begin
            if (!issued_ff) begin
               issued_in = 1'b1;
            end else if (mac_done) begin
               issued_in = 1'b0;
               k_in      = k_ff + 2'd1;
               if (phase_ff == P_PROJ) begin
                  emag_in[k_ff] = abs_mag(e_val);
               end
               if (k_ff == 2'd2) begin
                  k_in = 2'd0;
                  unique case (phase_ff)
                     P_LEN: begin
                        len2_in  = mac_acc[SUM_W-1:0];
                        phase_in = P_DOT;
                     end
                     P_DOT: begin
                        phase_in = P_PROJ;
                        // zero-length segment or point at or behind the start
                        if ((len2_ff == '0) || dot_le0) begin
                           t_in = '0;
                        end else if (mac_acc[SUM_W-1:0] >= len2_ff) begin
                           // point at or past the end
                           t_in = T_ONE;
                        end else begin
                           div_start = 1'b1;
                           state_in  = S_DIV;
                        end
                     end
                     P_PROJ: begin
                        phase_in = P_SQ;
                     end
                     P_SQ: begin
                        sqrt_start = 1'b1;
                        state_in   = S_SQRT;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               t_in      = {1'b0, div_quot};
               issued_in = 1'b0;
               state_in  = S_MAC;
            end
         end
         S_SQRT: begin
            if (sqrt_done) begin
               // saturate the root to the output range
               dist_in  = (sqrt_root[ROOT_W-1:DIST_W] != '0) ? '1 : sqrt_root[DIST_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_load) begin
               rsp_valid_in        = 1'b1;
               rsp_distance_in     = dist_ff;
               rsp_is_near_in      = near;
               rsp_path_blocked_in = blocked;
               rsp_list_done_in    = last_ff;
               blocked_in          = blocked && !last_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      d_ff                <= d_in;
      w_ff                <= w_in;
      emag_ff             <= emag_in;
      len2_ff             <= len2_in;
      t_ff                <= t_in;
      dist_ff             <= dist_in;
      last_ff             <= last_in;
      phase_ff            <= phase_in;
      k_ff                <= k_in;
      rsp_distance_ff     <= rsp_distance_in;
      rsp_is_near_ff      <= rsp_is_near_in;
      rsp_path_blocked_ff <= rsp_path_blocked_in;
      rsp_list_done_ff    <= rsp_list_done_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         blocked_ff   <= 1'b0;
         thr_ff       <= THRESH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         blocked_ff   <= blocked_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_distance     = rsp_distance_ff;
   assign rsp_is_near      = rsp_is_near_ff;
   assign rsp_path_blocked = rsp_path_blocked_ff;
   assign rsp_list_done    = rsp_list_done_ff;

   // serial units only finish while the sequencer waits on them
   a_mac_done_in_mac: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> (state_ff == S_MAC))
      else $error("mac finished outside its phase");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside its phase");

   a_t_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (t_ff <= T_ONE))
      else $error("projection parameter above one");

   a_list_end_clears: assert property (@(posedge clock) disable iff (reset)
      (out_load && last_ff) |=> !blocked_ff)
      else $error("blocked flag survived the end of a list");

endmodule
